@@ hw/rtl/message_tx_ring_with_burst_drain_macros.svh @@
// Assertion helpers for the sequencer of the transmit ring.
`ifndef MESSAGE_TX_RING_WITH_BURST_DRAIN_MACROS_SVH
`define MESSAGE_TX_RING_WITH_BURST_DRAIN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTRBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTRBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mtrbd_pkg.sv @@
package mtrbd_pkg;

	localparam int DATA_W = 8;
	localparam int KEEP_W = 13;
	localparam int PLIM_W = 7;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int OP_W = 2;

	localparam int RING_DEPTH_DEF = 8192;

	localparam logic [KEEP_W-1:0] KEEP_RST = 13'd1024;
	localparam logic [PLIM_W-1:0] PLIM_RST = 7'd63;
	localparam logic [PLIM_W-1:0] MAX_BURST = 7'd64;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLIM = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_BEGIN = 2'd0,
		OP_PUT   = 2'd1,
		OP_DRAIN = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

endpackage

@@ hw/rtl/mtrbd_if.sv @@
interface mtrbd_in_if;
	import mtrbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface mtrbd_out_if;
	import mtrbd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] tx_byte;
	logic              last_of_burst;

	modport source (output valid, output tx_byte, output last_of_burst, input ready);
	modport sink (input valid, input tx_byte, input last_of_burst, output ready);
endinterface

@@ hw/rtl/mtrbd_ram.sv @@
module mtrbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hw/rtl/mtrbd_alu.sv @@
module mtrbd_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] r
);
	// One adder; subtraction by adding the inverted operand with a carry in.
	logic [W-1:0] b_eff;

	assign b_eff = sub ? ~b : b;
	assign r     = a + b_eff + W'(sub);
endmodule

@@ hw/rtl/mtrbd_ctrl.sv @@
module mtrbd_ctrl #(
	parameter int RING_DEPTH = mtrbd_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mtrbd_in_if.sink                       cmd,
	mtrbd_out_if.source                    tx,
	input  logic                           cfg_we,
	input  logic [mtrbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtrbd_pkg::CFG_W-1:0]    cfg_data,
	output logic                           ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]  ram_waddr,
	output logic [mtrbd_pkg::DATA_W-1:0]   ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]  ram_raddr,
	input  logic [mtrbd_pkg::DATA_W-1:0]   ram_rdata
);
	import mtrbd_pkg::*;
	`include "message_tx_ring_with_burst_drain_macros.svh"

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int AW = ((PTR_W + 1 > KEEP_W) ? PTR_W + 1 : KEEP_W) + 1;
	localparam logic [AW-1:0] DEPTH_A = AW'(RING_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BL_DIFF,
		S_BL_FIX,
		S_BL_CMP,
		S_PUT,
		S_AV_DIFF,
		S_AV_FIX,
		S_AV_CLIP,
		S_ISSUE,
		S_SEND
	} state_t;

	state_t              state_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rp_q;
	logic                ovf_q;
	logic [KEEP_W-1:0]   keep_q;
	logic [PLIM_W-1:0]   plim_q;
	logic [AW-1:0]       acc_q;
	logic [PLIM_W-1:0]   cnt_q;
	logic [DATA_W-1:0]   byte_q;

	logic [AW-1:0]       alu_a;
	logic [AW-1:0]       alu_b;
	logic                alu_sub;
	logic [AW-1:0]       alu_r;
	logic [PTR_W-1:0]    inc_wrap;
	logic [PLIM_W-1:0]   lim;
	logic                put_full;
	logic                send_take;

	mtrbd_alu #(.W(AW)) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.r   (alu_r)
	);

	// Operand selection for the shared adder, one use per sequencer step.
	always_comb begin
		alu_a   = AW'(rp_q);
		alu_b   = AW'(1);
		alu_sub = 1'b0;
		case (state_q)
			S_BL_DIFF, S_AV_DIFF: begin
				alu_a   = AW'(wp_q);
				alu_b   = AW'(rp_q);
				alu_sub = 1'b1;
			end
			S_BL_FIX: begin
				alu_a = acc_q;
				alu_b = acc_q[AW-1] ? DEPTH_A : '0;
			end
			S_BL_CMP: begin
				alu_a   = AW'(keep_q);
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			S_PUT: begin
				alu_a = AW'(wp_q);
				alu_b = AW'(1);
			end
			S_AV_FIX: begin
				if (acc_q[AW-1]) begin
					alu_a   = DEPTH_A;
					alu_b   = AW'(rp_q);
					alu_sub = 1'b1;
				end else begin
					alu_a = acc_q;
					alu_b = '0;
				end
			end
			S_AV_CLIP: begin
				alu_a   = acc_q;
				alu_b   = AW'(lim);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = AW'(rp_q);
				alu_b   = AW'(1);
				alu_sub = 1'b0;
			end
		endcase
	end

	assign inc_wrap  = (alu_r == DEPTH_A) ? '0 : alu_r[PTR_W-1:0];
	assign lim       = (plim_q > MAX_BURST) ? MAX_BURST : plim_q;
	assign put_full  = (inc_wrap == rp_q);
	assign send_take = (state_q == S_SEND) && tx.ready;

	assign cmd.ready        = (state_q == S_IDLE);
	assign tx.valid         = (state_q == S_SEND);
	assign tx.tx_byte       = ram_rdata;
	assign tx.last_of_burst = (cnt_q == PLIM_W'(1));

	assign ram_we    = (state_q == S_PUT) && !put_full;
	assign ram_waddr = wp_q;
	assign ram_wdata = byte_q;
	assign ram_re    = (state_q == S_ISSUE) || (send_take && (cnt_q > PLIM_W'(1)));
	assign ram_raddr = (state_q == S_ISSUE) ? rp_q : inc_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			ovf_q   <= 1'b0;
			keep_q  <= KEEP_RST;
			plim_q  <= PLIM_RST;
			acc_q   <= '0;
			cnt_q   <= '0;
			byte_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEEP: keep_q <= cfg_data[KEEP_W-1:0];
					CFG_PLIM: plim_q <= cfg_data[PLIM_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					byte_q <= cmd.data_byte;
					if (cmd.valid) begin
						case (op_t'(cmd.operation))
							OP_BEGIN: state_q <= S_BL_DIFF;
							OP_PUT:   state_q <= ovf_q ? S_IDLE : S_PUT;
							OP_DRAIN: state_q <= S_AV_DIFF;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_BL_DIFF: begin
					acc_q   <= alu_r;
					state_q <= S_BL_FIX;
				end
				S_BL_FIX: begin
					acc_q   <= alu_r;
					state_q <= S_BL_CMP;
				end
				S_BL_CMP: begin
					// A negative difference means the backlog exceeds the keep limit.
					if (alu_r[AW-1]) begin
						rp_q <= wp_q;
					end
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				S_PUT: begin
					if (put_full) begin
						ovf_q <= 1'b1;
					end else begin
						wp_q <= inc_wrap;
					end
					state_q <= S_IDLE;
				end
				S_AV_DIFF: begin
					acc_q   <= alu_r;
					state_q <= (wp_q == rp_q) ? S_IDLE : S_AV_FIX;
				end
				S_AV_FIX: begin
					acc_q   <= alu_r;
					state_q <= S_AV_CLIP;
				end
				S_AV_CLIP: begin
					cnt_q   <= alu_r[AW-1] ? acc_q[PLIM_W-1:0] : lim;
					state_q <= (lim == '0) ? S_IDLE : S_ISSUE;
				end
				S_ISSUE: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (tx.ready) begin
						rp_q  <= inc_wrap;
						cnt_q <= cnt_q - PLIM_W'(1);
						if (cnt_q == PLIM_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MTRBD_ASSERT_IMP(a_ready_excl_valid, clk, arst_n, cmd.ready, !tx.valid, "accepting while sending")
	`MTRBD_ASSERT_IMP(a_send_count, clk, arst_n, tx.valid, cnt_q != '0, "sending with empty count")
	`MTRBD_ASSERT_NXT(a_last_returns_idle, clk, arst_n, tx.valid && tx.ready && tx.last_of_burst, cmd.ready, "no idle after last word")
	`MTRBD_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, (AW'(rp_q) < DEPTH_A) && (AW'(wp_q) < DEPTH_A), "pointer past ring end")
	`MTRBD_ASSERT_IMP(a_no_write_in_burst, clk, arst_n, tx.valid, !ram_we, "ring written during burst")
endmodule

@@ hw/rtl/message_tx_ring_with_burst_drain.sv @@
// Message transmit ring with burst drain.
// Commands arrive as words on the cmd channel (valid/ready); each carries an
// operation and a byte. Begin-message discards the queued backlog when it is
// larger than the keep limit and clears the overflow latch. Put appends one byte,
// or sets the latch when the ring is full, after which puts are dropped until the
// next begin-message. Drain sends up to packet_limit bytes (at most 64), stopping
// at the end of the store, as words on the tx channel with last_of_burst on the final one.
// Steps, from the accepting edge: begin passes the states BL_DIFF, BL_FIX and BL_CMP,
// put passes PUT (none when the set latch drops it), an unused code none, and a drain of
// an empty ring AV_DIFF only. Any other drain passes AV_DIFF, AV_FIX and AV_CLIP to work
// out the burst length (with a zero packet limit it ends there and sends nothing), then
// ISSUE for the first read, after which one byte leaves per cycle while tx.ready is high;
// the one shared adder in the sequencer and the registered read port of the ring memory
// call for these steps. cmd.ready is low until the command has finished.
// When the receiver stalls, the current byte and its last mark hold steady and the
// memory is not read again until the word is taken.
// Reset clears the pointers, the latch and the registers to their defaults
// (keep limit 1024, packet limit 63) at once; the store itself is not cleared.
// Configuration writes are taken on any cycle that cfg_we is high.
module message_tx_ring_with_burst_drain #(
	parameter int RING_DEPTH = mtrbd_pkg::RING_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mtrbd_in_if.sink                        cmd,
	mtrbd_out_if.source                     tx,
	input  logic                            cfg_we,
	input  logic [mtrbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtrbd_pkg::CFG_W-1:0]     cfg_data
);
	import mtrbd_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PTR_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// Sequencer: pointers, latch, registers and the shared adder.
	mtrbd_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tx        (tx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Byte store; its read register doubles as the output word register.
	mtrbd_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule
